// ===== hdl/hxp_pkg.sv =====
// Package: phase type, character codes, digit decode and step result for the hex parser.
`timescale 1ns / 1ps

package hxp_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned NIBBLE_W = 4;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
   localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LF_HEX = 8'h66;
   localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

   localparam logic [NIBBLE_W-1:0] ALPHA_BASE = 4'd10;

   typedef enum logic [2:0] {
      PH_DONE   = 3'd0,
      PH_SPACE  = 3'd1,
      PH_ZERO   = 3'd2,
      PH_DIGITS = 3'd3
   } phase_type;

   typedef struct packed {
      logic                 valid;
      logic [NIBBLE_W-1:0]  nibble;
   } digit_type;

   // State of a parse between characters
   typedef struct packed {
      phase_type            phase;
      logic [WORD_W-1:0]    accum;
      logic                 have_digit;
      logic [COUNT_W-1:0]   count;
   } parse_state_type;

   // Result word produced when a parse ends
   typedef struct packed {
      logic                 valid;
      logic [WORD_W-1:0]    value;
      logic                 ok;
      logic [COUNT_W-1:0]   consumed;
   } result_type;

   function automatic digit_type hex_digit(input logic [CHAR_W-1:0] c);
      digit_type d;
      d.valid  = 1'b1;
      d.nibble = '0;
      if (c inside {[CH_0:CH_9]}) begin
         d.nibble = NIBBLE_W'(c - CH_0);
      end else if (c inside {[CH_UA:CH_UF]}) begin
         d.nibble = NIBBLE_W'(c - CH_UA) + ALPHA_BASE;
      end else if (c inside {[CH_LA:CH_LF_HEX]}) begin
         d.nibble = NIBBLE_W'(c - CH_LA) + ALPHA_BASE;
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] n);
      return (n == {COUNT_W{1'b1}}) ? n : n + 1'b1;
   endfunction

endpackage

// ===== hdl/hxp_step.sv =====
// Combinational step of the hex parser: one character against the current parse state.
`timescale 1ns / 1ps

module hxp_step (
   input  logic [hxp_pkg::CHAR_W-1:0] ch,
   input  logic                       start_req,
   input  hxp_pkg::parse_state_type   cur,
   output hxp_pkg::parse_state_type   nxt,
   output hxp_pkg::result_type        res
);
   import hxp_pkg::*;

   parse_state_type eff;
   digit_type       dig;
   phase_type       nxt_phase;
   logic            is_blank;
   logic            is_end;
   logic            is_zero;
   logic            is_x;
   logic            take_digits;

   always_comb begin
      eff = cur;
      // start wipes the running parse
      if (start_req) begin
         eff.phase      = PH_SPACE;
         eff.accum      = '0;
         eff.have_digit = 1'b0;
         eff.count      = '0;
      end
   end

   assign dig      = hex_digit(ch);
   assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
   assign is_end   = ch inside {CH_NUL, CH_SPACE, CH_TAB, CH_CR, CH_LF};
   assign is_zero  = (ch == CH_0);
   assign is_x     = (ch == CH_LX) || (ch == CH_UX);

   always_comb begin
      case (eff.phase)
         PH_DONE:   take_digits = 1'b0;
         PH_SPACE:  take_digits = !is_blank && !is_zero;
         PH_ZERO:   take_digits = !is_x;
         PH_DIGITS: take_digits = 1'b1;
         default:   take_digits = 1'b0;
      endcase
   end

   // next phase
   always_comb begin
      case (eff.phase)
         PH_DONE:  nxt_phase = PH_DONE;
         PH_SPACE: begin
            if (is_blank)     nxt_phase = PH_SPACE;
            else if (is_zero) nxt_phase = PH_ZERO;
            else if (is_end || !dig.valid) nxt_phase = PH_DONE;
            else              nxt_phase = PH_DIGITS;
         end
         PH_ZERO, PH_DIGITS: begin
            if (!take_digits) nxt_phase = PH_DIGITS;
            else if (is_end || !dig.valid) nxt_phase = PH_DONE;
            else              nxt_phase = PH_DIGITS;
         end
         default:  nxt_phase = PH_DONE;
      endcase
   end

   // datapath and result
   always_comb begin
      nxt.phase      = nxt_phase;
      nxt.accum      = eff.accum;
      nxt.have_digit = eff.have_digit;
      nxt.count      = eff.count;
      res            = '0;
      if (take_digits) begin
         if (is_end || !dig.valid) begin
            res.valid      = 1'b1;
            res.ok         = is_end && eff.have_digit;
            res.value      = res.ok ? eff.accum : '0;
            res.consumed   = res.ok ? eff.count : '0;
            nxt.accum      = '0;
            nxt.have_digit = 1'b0;
            nxt.count      = '0;
         end else begin
            nxt.accum      = {eff.accum[WORD_W-NIBBLE_W-1:0], dig.nibble};
            nxt.have_digit = 1'b1;
            nxt.count      = sat_inc(eff.count);
         end
      end else if (eff.phase == PH_SPACE) begin
         nxt.count = sat_inc(eff.count);
         if (is_zero) begin
            nxt.accum      = '0;
            nxt.have_digit = 1'b1;
         end
      end else if (eff.phase == PH_ZERO) begin
         // zero then x forms the prefix, drop the digit
         nxt.accum      = '0;
         nxt.have_digit = 1'b0;
         nxt.count      = sat_inc(eff.count);
      end
   end

endmodule

// ===== hdl/hex_text_to_word_parser_top.sv =====
// Top level of the hex text to word parser: input register, parse step, result register.
//
//   channel | direction | ports                                   | handshake
//   req     | in        | req_ch, req_start_req                   | req_valid / req_stall
//   rsp     | out       | rsp_value, rsp_ok, rsp_consumed         | rsp_valid / rsp_stall
//
// One character a cycle unless req_stall: a character is held in the input register and is
// decoded into the parse state and, when the parse ends, into the result register.
// The result word of the character that ends the parse is registered in the result register.
// Reset clears the parse to done; a character with start_req low is then dropped.
// rsp_stall with a full result register holds the input register, which raises req_stall.
`timescale 1ns / 1ps

module hex_text_to_word_parser_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [hxp_pkg::CHAR_W-1:0]  req_ch,
   input  logic                        req_start_req,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [hxp_pkg::WORD_W-1:0]  rsp_value,
   output logic                        rsp_ok,
   output logic [hxp_pkg::COUNT_W-1:0] rsp_consumed
);
   import hxp_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]   in_ch_ff;
   logic                in_start_ff;
   parse_state_type     state_ff, state_in;
   parse_state_type     step_state;
   result_type          step_res;
   result_type          out_ff, out_in;
   logic                out_free;
   logic                fire;

   // result register free this cycle, either empty or being taken
   assign out_free  = !out_ff.valid || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   hxp_step u_step (
      .ch        (in_ch_ff),
      .start_req (in_start_ff),
      .cur       (state_ff),
      .nxt       (step_state),
      .res       (step_res)
   );

   always_comb begin
      in_valid_in = req_stall ? in_valid_ff : req_valid;
      state_in    = fire ? step_state : state_ff;
      out_in      = out_ff;
      if (fire && step_res.valid) begin
         out_in = step_res;
      end else if (!rsp_stall) begin
         out_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         state_ff.phase       <= PH_DONE;
         state_ff.accum       <= '0;
         state_ff.have_digit  <= 1'b0;
         state_ff.count       <= '0;
         out_ff.valid         <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         out_ff       <= out_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_ch_ff    <= req_ch;
         in_start_ff <= req_start_req;
      end
   end

   assign rsp_valid    = out_ff.valid;
   assign rsp_value    = out_ff.value;
   assign rsp_ok       = out_ff.ok;
   assign rsp_consumed = out_ff.consumed;

endmodule

// ===== hdl/hxp_checker.sv =====
// Port checker for the hex parser top level, with its bind.
`timescale 1ns / 1ps

module hxp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [hxp_pkg::WORD_W-1:0]  rsp_value,
   input logic                        rsp_ok,
   input logic [hxp_pkg::COUNT_W-1:0] rsp_consumed
);
   import hxp_pkg::*;

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_ok)
         && $stable(rsp_consumed))
      else $error("stalled result word changed");

   // failure carries zero value and zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_value == '0 && rsp_consumed == '0)
      else $error("failed parse with nonzero payload");

   // success needs at least one digit consumed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok |-> rsp_consumed != '0)
      else $error("successful parse with zero count");

   // nothing shows straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

endmodule

bind hex_text_to_word_parser_top hxp_checker u_hxp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_value    (rsp_value),
   .rsp_ok       (rsp_ok),
   .rsp_consumed (rsp_consumed)
);
